[rtl/apla_pkg.sv]
// shared types, codes and constants of the adjacent pair lock arbiter
package apla_pkg;

  localparam int CLIENT_W      = 4;
  localparam int SEAT_W        = 5;
  localparam int MAX_SEATS_DEF = 16;
  localparam logic [SEAT_W-1:0] SEAT_RESET = 5'd5;
  localparam int OUT_DEPTH     = 4;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    KIND_GRANT  = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_SHIFT,
    ST_GRANT
  } state_t;

  typedef struct packed {
    logic [CLIENT_W-1:0] target;
    kind_t               kind;
    logic                last;
  } result_t;

  typedef struct packed {
    logic in_range;
    logic free;
  } pair_stat_t;

endpackage

[rtl/apla_ram.sv]
// generic single write port ram with registered read
module apla_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/apla_pair_unit.sv]
// shared pair check: range, resource mask and freedom of one client's pair
module apla_pair_unit #(
  parameter int MAX_SEATS = apla_pkg::MAX_SEATS_DEF
) (
  input  logic [apla_pkg::CLIENT_W-1:0] subject,
  input  logic [apla_pkg::SEAT_W-1:0]   seats,
  input  logic [MAX_SEATS-1:0]          res_free,
  output logic [MAX_SEATS-1:0]          mask,
  output apla_pkg::pair_stat_t          stat
);
  import apla_pkg::*;

  logic [SEAT_W-1:0] subj_ext;
  logic [SEAT_W-1:0] left;

  assign subj_ext = SEAT_W'(subject);

  // left neighbour wraps to the top seat in use
  assign left = (subj_ext == '0) ? (seats - 1'b1) : (subj_ext - 1'b1);

  always_comb begin
    for (int unsigned k = 0; k < MAX_SEATS; k++) begin
      mask[k] = (k == 32'(left)) || (k == 32'(subj_ext));
    end
  end

  assign stat.in_range = subj_ext < seats;
  assign stat.free     = (res_free & mask) == mask;

endmodule

[rtl/apla_out_fifo.sv]
// small result queue between the sequencer and the output channel
module apla_out_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  apla_pkg::result_t     push_word,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output apla_pkg::result_t     out_word
);
  import apla_pkg::*;

  localparam int PW = $clog2(OUT_DEPTH);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  result_t         mem_r [OUT_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid = count_r != '0;
  assign out_word  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the two words a single item may produce
  assign room      = 32'(count_r) + 2 <= OUT_DEPTH;

  always_comb begin
    wr_ptr_nxt = push ? PW'(32'(wr_ptr_r) + 1 == OUT_DEPTH ? 0 : 32'(wr_ptr_r) + 1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(32'(rd_ptr_r) + 1 == OUT_DEPTH ? 0 : 32'(rd_ptr_r) + 1) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

[rtl/adjacent_pair_lock_arbiter_unit.sv]
// request: result word queued in the check state after accept; no word if put on the wait list or out of range
// release: check, scan for the first waiter whose pair is free, then compaction one entry a cycle
// one item at a time; next item accepted on return to idle with two queue slots free
// results leave through a 4 word queue, so output stalls do not block the sequencer
// reset (rst_n low, synchronous): all resources free, list empty, seat count 5
// wait list storage is not cleared; entries beyond the fill count are never read
module adjacent_pair_lock_arbiter_unit #(
  parameter int MAX_SEATS = apla_pkg::MAX_SEATS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [3:0] client
  input  logic                        in_tuser,   // [0] operation
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [3:0] target
  output logic [1:0]                  out_tuser,  // [1:0] kind
  output logic                        out_tlast,
  input  logic                        cfg_wr_en,
  input  logic [apla_pkg::SEAT_W-1:0] cfg_wr_data
);
  import apla_pkg::*;

  localparam int AW = $clog2(MAX_SEATS);
  localparam int CW = $clog2(MAX_SEATS + 1);

  state_t               state_r, state_nxt;
  logic [SEAT_W-1:0]    seat_count_r;
  logic [SEAT_W-1:0]    seats;
  logic [MAX_SEATS-1:0] res_r, res_nxt;
  logic [CW-1:0]        wait_count_r, wait_count_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        idx_inc, idx_dec;
  logic [CLIENT_W-1:0]  client_r, client_nxt;
  logic                 op_r, op_nxt;
  logic [CLIENT_W-1:0]  grant_r, grant_nxt;

  logic                 accept;
  logic                 more;
  logic                 hit;
  logic                 list_full;
  logic                 room;

  logic [CLIENT_W-1:0]  subject;
  logic [MAX_SEATS-1:0] mask;
  pair_stat_t           stat;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_wa, ram_ra;
  logic [CLIENT_W-1:0]  ram_wd, ram_rd;

  logic                 push;
  result_t              push_word, out_word;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && room;

  always_comb begin
    if (seat_count_r < SEAT_W'(2)) begin
      seats = SEAT_W'(2);
    end else if (32'(seat_count_r) > MAX_SEATS) begin
      seats = SEAT_W'(MAX_SEATS);
    end else begin
      seats = seat_count_r;
    end
  end

  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign more      = idx_inc < wait_count_r;
  assign hit       = stat.in_range && stat.free;
  assign list_full = 32'(wait_count_r) >= 32'(seats);

  // during the scan the unit checks the waiter just read, otherwise the caller
  assign subject = (state_r == ST_SCAN) ? ram_rd : client_r;

  apla_pair_unit #(
    .MAX_SEATS (MAX_SEATS)
  ) u_pair (
    .subject  (subject),
    .seats    (seats),
    .res_free (res_r),
    .mask     (mask),
    .stat     (stat)
  );

  apla_ram #(
    .WIDTH (CLIENT_W),
    .DEPTH (MAX_SEATS)
  ) u_wait_list (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .re      (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  apla_out_fifo u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = 8'(out_word.target);
  assign out_tuser = out_word.kind;
  assign out_tlast = out_word.last;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.in_range && op_r == OP_RELEASE && wait_count_r != '0) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_nxt = more ? ST_SHIFT : ST_GRANT;
        end else begin
          state_nxt = more ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        state_nxt = more ? ST_SHIFT : ST_GRANT;
      end
      ST_GRANT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    res_nxt        = res_r;
    wait_count_nxt = wait_count_r;
    idx_nxt        = idx_r;
    client_nxt     = client_r;
    op_nxt         = op_r;
    grant_nxt      = grant_r;
    ram_we         = 1'b0;
    ram_wa         = '0;
    ram_wd         = '0;
    ram_re         = 1'b0;
    ram_ra         = '0;
    push           = 1'b0;
    push_word      = '{target: client_r, kind: KIND_ACK, last: 1'b1};
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          client_nxt = in_tdata[CLIENT_W-1:0];
          op_nxt     = in_tuser;
        end
      end
      ST_CHECK: begin
        if (stat.in_range) begin
          if (op_r == OP_REQUEST) begin
            if (stat.free) begin
              res_nxt        = res_r & ~mask;
              push           = 1'b1;
              push_word.kind = KIND_GRANT;
            end else if (list_full) begin
              push           = 1'b1;
              push_word.kind = KIND_REJECT;
            end else begin
              ram_we         = 1'b1;
              ram_wa         = wait_count_r[AW-1:0];
              ram_wd         = client_r;
              wait_count_nxt = wait_count_r + 1'b1;
            end
          end else begin
            res_nxt = res_r | mask;
            if (wait_count_r == '0) begin
              push = 1'b1;
            end else begin
              ram_re  = 1'b1;
              ram_ra  = '0;
              idx_nxt = '0;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          res_nxt   = res_r & ~mask;
          grant_nxt = ram_rd;
        end
        if (more) begin
          ram_re  = 1'b1;
          ram_ra  = idx_inc[AW-1:0];
          idx_nxt = idx_inc;
        end else if (hit) begin
          wait_count_nxt = wait_count_r - 1'b1;
          push           = 1'b1;
          push_word.last = 1'b0;
        end else begin
          push = 1'b1;
        end
      end
      ST_SHIFT: begin
        // close the gap: entry idx moves down one place
        ram_we = 1'b1;
        ram_wa = idx_dec[AW-1:0];
        ram_wd = ram_rd;
        if (more) begin
          ram_re  = 1'b1;
          ram_ra  = idx_inc[AW-1:0];
          idx_nxt = idx_inc;
        end else begin
          wait_count_nxt = wait_count_r - 1'b1;
          push           = 1'b1;
          push_word.last = 1'b0;
        end
      end
      ST_GRANT: begin
        push      = 1'b1;
        push_word = '{target: grant_r, kind: KIND_GRANT, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seat_count_r <= SEAT_RESET;
      res_r        <= '1;
      wait_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      res_r        <= res_nxt;
      wait_count_r <= wait_count_nxt;
      if (cfg_wr_en) begin
        seat_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    client_r <= client_nxt;
    op_r     <= op_nxt;
    grant_r  <= grant_nxt;
  end

  a_check_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHECK |-> $past(in_tvalid && in_tready))
    else $error("pair check without an accepted word");

  a_grant_shrinks_list : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT && $past(state_r) != ST_GRANT) |->
      wait_count_r == $past(wait_count_r) - 1'b1)
    else $error("waiter grant without removal from the list");

  a_scan_in_list : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SHIFT) |-> idx_r < wait_count_r)
    else $error("scan index beyond the wait list");

  a_list_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    32'(wait_count_r) <= MAX_SEATS)
    else $error("wait list overfilled");

endmodule
